@@ hw/rtl/rtsp_th_pkg.sv @@
// Shared types, keyword tables and the segment decode function of the transport header parser.
package rtsp_th_pkg;

    localparam int KW_COUNT         = 20;
    localparam int DEST_BYTES_DEF   = 64;
    localparam int SOURCE_BYTES_DEF = 64;
    localparam logic [31:0] SAT_COUNT = 32'h7FFF_FFFF;

    // Keyword indexes, in match priority order
    localparam int KW_RTP_UDP    = 0;
    localparam int KW_RTP_TCP    = 1;
    localparam int KW_RAW_UDP    = 2;
    localparam int KW_RTP_AVP    = 3;
    localparam int KW_UNICAST    = 4;
    localparam int KW_MULTICAST  = 5;
    localparam int KW_PLAY       = 6;
    localparam int KW_PLAY_Q     = 7;
    localparam int KW_RECORD     = 8;
    localparam int KW_RECORD_Q   = 9;
    localparam int KW_DEST       = 10;
    localparam int KW_SOURCE     = 11;
    localparam int KW_SSRC       = 12;
    localparam int KW_SERVER     = 13;
    localparam int KW_PORT       = 14;
    localparam int KW_CLIENT     = 15;
    localparam int KW_INTERLEAVE = 16;
    localparam int KW_TTL        = 17;
    localparam int KW_LAYERS     = 18;
    localparam int KW_APPEND     = 19;

    // Bit k set: keyword k ignores letter case / takes a value after it
    localparam logic [KW_COUNT-1:0] KW_NOCASE = 20'b1000_0001_1111_1111_1111;
    localparam logic [KW_COUNT-1:0] KW_PREFIX = 20'b0111_1111_1100_0000_0000;

    // Character codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef enum logic [4:0] {
        KIND_NONE, KIND_TRANSPORT, KIND_MULTICAST, KIND_MODE, KIND_APPEND,
        KIND_CLIENT, KIND_SERVER, KIND_MCAST_PORT, KIND_INTERLEAVED, KIND_TTL,
        KIND_LAYERS, KIND_SSRC, KIND_DEST_CHAR, KIND_SOURCE_CHAR, KIND_DEST_END,
        KIND_SOURCE_END, KIND_ERROR
    } kind_t;

    // Number scanner phases
    typedef enum logic [2:0] {
        PH_START, PH_FIRST, PH_DASH, PH_SECOND, PH_AFTER1, PH_AFTER2, PH_NONE
    } phase_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] v1;
        logic [15:0] v2;
    } res_t;

    typedef struct packed {
        logic        last_of_item;
        logic        header_done;
        logic [15:0] v2;
        logic [31:0] v1;
        kind_t       kind;
    } out_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
        return r;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] r;
        case (k)
            KW_RTP_UDP, KW_RTP_TCP, KW_RAW_UDP, KW_PLAY_Q, KW_RECORD: r = 4'd11;
            KW_RTP_AVP, KW_UNICAST, KW_SOURCE, KW_LAYERS:            r = 4'd7;
            KW_MULTICAST, KW_PLAY:                                   r = 4'd9;
            KW_RECORD_Q:                                             r = 4'd13;
            KW_DEST, KW_SERVER, KW_CLIENT, KW_INTERLEAVE:            r = 4'd12;
            KW_SSRC, KW_PORT:                                        r = 4'd5;
            KW_TTL:                                                  r = 4'd4;
            default:                                                 r = 4'd6;
        endcase
        return r;
    endfunction

    // Lower-case character of keyword k at position pos (pos below its length)
    function automatic logic [7:0] kw_byte(input int k, input logic [3:0] pos);
        logic [103:0] txt;
        logic [3:0]   idx;
        case (k)
            KW_RTP_UDP:    txt = 104'("rtp/avp/udp");
            KW_RTP_TCP:    txt = 104'("rtp/avp/tcp");
            KW_RAW_UDP:    txt = 104'("raw/raw/udp");
            KW_RTP_AVP:    txt = 104'("rtp/avp");
            KW_UNICAST:    txt = 104'("unicast");
            KW_MULTICAST:  txt = 104'("multicast");
            KW_PLAY:       txt = 104'("mode=play");
            KW_PLAY_Q:     txt = 104'("mode=\"play\"");
            KW_RECORD:     txt = 104'("mode=record");
            KW_RECORD_Q:   txt = 104'("mode=\"record\"");
            KW_DEST:       txt = 104'("destination=");
            KW_SOURCE:     txt = 104'("source=");
            KW_SSRC:       txt = 104'("ssrc=");
            KW_SERVER:     txt = 104'({"server_", "port="});
            KW_PORT:       txt = 104'("port=");
            KW_CLIENT:     txt = 104'({"client_", "port="});
            KW_INTERLEAVE: txt = 104'("interleaved=");
            KW_TTL:        txt = 104'("ttl=");
            KW_LAYERS:     txt = 104'("layers=");
            default:       txt = 104'("append");
        endcase
        idx = kw_len(k) - pos - 4'd1;
        return txt[idx*8 +: 8];
    endfunction

    // Result of closing a segment
    function automatic res_t finish_seg(input logic [KW_COUNT-1:0] cand,
                                        input logic [7:0] seglen,
                                        input logic [31:0] nf,
                                        input logic [15:0] ns,
                                        input phase_t ph,
                                        input logic [7:0] strlen);
        res_t        r;
        logic        found;
        int          hit;
        logic        one;
        logic        two;
        logic        m;
        logic [15:0] f;
        r     = '0;
        found = 1'b0;
        hit   = 0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (k == KW_SSRC)     m = (seglen == 8'd13);
            else if (KW_PREFIX[k]) m = (seglen >= {4'd0, kw_len(k)});
            else                   m = (seglen == {4'd0, kw_len(k)});
            if (!found && cand[k] && m) begin
                found = 1'b1;
                hit   = k;
            end
        end
        one = (ph == PH_FIRST) || (ph == PH_DASH) || (ph == PH_AFTER1);
        two = (ph == PH_SECOND) || (ph == PH_AFTER2);
        f   = nf[15:0] & 16'hFFFE;
        if (found) begin
            case (hit)
                KW_RTP_UDP, KW_RTP_AVP: begin
                    r.valid = 1'b1; r.kind = KIND_TRANSPORT;
                end
                KW_RTP_TCP: begin
                    r.valid = 1'b1; r.kind = KIND_TRANSPORT; r.v1 = 32'd1;
                end
                KW_RAW_UDP: begin
                    r.valid = 1'b1; r.kind = KIND_TRANSPORT; r.v1 = 32'd2;
                end
                KW_UNICAST: begin
                    r.valid = 1'b1; r.kind = KIND_MULTICAST;
                end
                KW_MULTICAST: begin
                    r.valid = 1'b1; r.kind = KIND_MULTICAST; r.v1 = 32'd1;
                end
                KW_PLAY, KW_PLAY_Q: begin
                    r.valid = 1'b1; r.kind = KIND_MODE; r.v1 = 32'd1;
                end
                KW_RECORD, KW_RECORD_Q: begin
                    r.valid = 1'b1; r.kind = KIND_MODE; r.v1 = 32'd2;
                end
                KW_DEST: begin
                    r.valid = 1'b1; r.kind = KIND_DEST_END; r.v1 = {24'd0, strlen};
                end
                KW_SOURCE: begin
                    r.valid = 1'b1; r.kind = KIND_SOURCE_END; r.v1 = {24'd0, strlen};
                end
                KW_SSRC: begin
                    r.valid = 1'b1; r.kind = KIND_SSRC; r.v1 = nf;
                end
                KW_SERVER, KW_PORT, KW_CLIENT: begin
                    r.kind = (hit == KW_SERVER) ? KIND_SERVER :
                             (hit == KW_PORT) ? KIND_MCAST_PORT : KIND_CLIENT;
                    r.valid = one || two;
                    if (two) begin
                        r.v1 = nf; r.v2 = ns;
                    end else begin
                        r.v1 = {16'd0, f}; r.v2 = f + 16'd1;
                    end
                end
                KW_INTERLEAVE: begin
                    r.kind  = KIND_INTERLEAVED;
                    r.valid = one || two;
                    r.v1    = nf;
                    if (two)                 r.v2 = ns;
                    else if (nf >= 32'hFFFF) r.v2 = 16'hFFFF;
                    else                     r.v2 = nf[15:0] + 16'd1;
                end
                KW_TTL, KW_LAYERS: begin
                    r.kind  = (hit == KW_TTL) ? KIND_TTL : KIND_LAYERS;
                    r.valid = one;
                    r.v1    = nf;
                end
                default: begin
                    r.valid = 1'b1; r.kind = KIND_APPEND; r.v1 = 32'd1;
                end
            endcase
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/rtsp_transport_header_parser.sv @@
// Top level of the RTSP Transport header parser: byte register, decode, result queue.
//
// Takes the header value one byte per beat and gives one byte per clock sustained: each byte
// is registered, decoded by one pass of matcher and accumulator logic and pushed as zero, one
// or two results into a four-entry result queue. Both results of a byte are written into the
// queue in the same cycle, the first ahead of the second. s_tready falls only while the queue
// has fewer than two free entries, so with a downstream that takes every beat no byte is ever
// stalled. m_tlast marks the result that ends or fails the header; m_tdata bit 53 marks the
// last result caused by one input byte.
module rtsp_transport_header_parser #(
    parameter int DEST_BYTES   = rtsp_th_pkg::DEST_BYTES_DEF,
    parameter int SOURCE_BYTES = rtsp_th_pkg::SOURCE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [4:0] item_kind, [36:5] value_first, [52:37] value_second,
                                   // [53] last_of_item, [55:54] zero
    output logic        m_tlast    // header_done
);
    import rtsp_th_pkg::*;

    // Input byte register
    logic        st1_valid_reg;
    logic [7:0]  st1_byte_reg;
    logic        st1_eot_reg;
    logic        proc;

    // Parser state
    logic [7:0]          seg_len_reg,  seg_len_next;
    logic [KW_COUNT-1:0] cand_reg,     cand_next;
    logic [31:0]         nf_reg,       nf_next;
    logic [15:0]         ns_reg,       ns_next;
    phase_t              phase_reg,    phase_next;
    logic [7:0]          str_len_reg,  str_len_next;
    logic                stopped_reg,  stopped_next;

    // Result queue
    out_t        fifo_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;
    logic [1:0]  push_n;
    out_t        res0, res1;
    logic        pop;

    assign proc     = st1_valid_reg && (count_reg <= 3'd2);
    assign s_tready = !st1_valid_reg || proc;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            st1_byte_reg <= s_tdata;
            st1_eot_reg  <= s_tlast;
        end
    end

    // Decode of one byte
    logic [7:0]          c;
    logic                eot, is_term, is_semi;
    logic [KW_COUNT-1:0] cand_tk;
    logic                val_found;
    int                  valk;
    logic                nocase_k;
    logic [7:0]          cmp_c;
    logic                is_str, is_num, fail, done;
    logic [8:0]          str_inc;
    logic [8:0]          limit;
    logic [31:0]         nf_tk;
    logic [15:0]         ns_tk;
    phase_t              ph_tk;
    logic [7:0]          str_tk;
    logic                is_dec, is_hex, hexmode, pairmode, satmode, is_digit;
    logic [3:0]          dig;
    logic [31:0]         nf_x10;
    logic [31:0]         sat_lim;
    logic [20:0]         ns_v;
    res_t                fin, chr;
    logic                fin_use;

    always_comb begin
        c       = st1_byte_reg;
        eot     = st1_eot_reg;
        is_term = (c == CH_COMMA) || (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
        is_semi = (c == CH_SEMI);

        // keyword candidates and the keyword whose value this byte belongs to
        cand_tk   = cand_reg;
        val_found = 1'b0;
        valk      = 0;
        for (int k = 0; k < KW_COUNT; k++) begin
            nocase_k = KW_NOCASE[k] && !(k == KW_APPEND && seg_len_reg == 8'd0);
            cmp_c    = nocase_k ? to_lower(c) : c;
            if (cand_reg[k]) begin
                if (seg_len_reg < {4'd0, kw_len(k)}) begin
                    if (cmp_c != kw_byte(k, seg_len_reg[3:0])) cand_tk[k] = 1'b0;
                end else if (KW_PREFIX[k]) begin
                    if (!val_found) begin
                        val_found = 1'b1;
                        valk      = k;
                    end
                end else begin
                    cand_tk[k] = 1'b0;
                end
            end
        end

        // destination / source text
        is_str  = val_found && (valk == KW_DEST || valk == KW_SOURCE);
        limit   = (valk == KW_DEST) ? 9'(DEST_BYTES) : 9'(SOURCE_BYTES);
        str_inc = {1'b0, str_len_reg} + 9'd1;
        fail    = is_str && (str_inc >= limit);
        str_tk  = str_len_reg;
        chr     = '0;
        if (is_str) begin
            chr.valid = 1'b1;
            if (fail) begin
                chr.kind = KIND_ERROR;
            end else begin
                chr.kind = (valk == KW_DEST) ? KIND_DEST_CHAR : KIND_SOURCE_CHAR;
                chr.v1   = {24'd0, c};
                str_tk   = str_inc[7:0];
            end
        end

        // number accumulation
        is_num   = val_found && (valk >= KW_SSRC);
        hexmode  = (valk == KW_SSRC);
        pairmode = (valk >= KW_SERVER) && (valk <= KW_INTERLEAVE);
        satmode  = (valk >= KW_INTERLEAVE);
        is_dec   = (c >= 8'h30) && (c <= 8'h39);
        is_hex   = hexmode && (to_lower(c) >= 8'h61) && (to_lower(c) <= 8'h66);
        is_digit = is_dec || is_hex;
        dig      = is_dec ? 4'(c - 8'h30) : 4'(to_lower(c) - 8'h57);
        nf_x10   = (nf_reg << 3) + (nf_reg << 1);
        sat_lim  = (dig > 4'd7) ? 32'd214748363 : 32'd214748364;
        ns_v     = {5'd0, ns_reg} * 21'd10 + {17'd0, dig};
        nf_tk    = nf_reg;
        ns_tk    = ns_reg;
        ph_tk    = phase_reg;
        if (is_num) begin
            unique case (phase_reg)
                PH_START: begin
                    if (is_digit) begin
                        nf_tk = {28'd0, dig}; ph_tk = PH_FIRST;
                    end else begin
                        ph_tk = PH_NONE;
                    end
                end
                PH_FIRST: begin
                    if (is_digit) begin
                        if (hexmode)       nf_tk = {nf_reg[27:0], dig};
                        else if (satmode)  nf_tk = (nf_reg > sat_lim) ? SAT_COUNT
                                                   : nf_x10 + {28'd0, dig};
                        else               nf_tk = {16'd0, nf_x10[15:0] + {12'd0, dig}};
                    end else if (pairmode && c == CH_DASH) begin
                        ph_tk = PH_DASH;
                    end else begin
                        ph_tk = PH_AFTER1;
                    end
                end
                PH_DASH: begin
                    if (is_digit) begin
                        ns_tk = {12'd0, dig}; ph_tk = PH_SECOND;
                    end else begin
                        ph_tk = PH_AFTER1;
                    end
                end
                PH_SECOND: begin
                    if (is_digit) begin
                        ns_tk = (satmode && ns_v > 21'hFFFF) ? 16'hFFFF : ns_v[15:0];
                    end else begin
                        ph_tk = PH_AFTER2;
                    end
                end
                default: ;
            endcase
        end

        // segment close, on the old state for terminators and semicolons, else on the updated one
        if (is_term || is_semi)
            fin = finish_seg(cand_reg, seg_len_reg, nf_reg, ns_reg, phase_reg, str_len_reg);
        else
            fin = finish_seg(cand_tk, (seg_len_reg == 8'hFF) ? 8'hFF : seg_len_reg + 8'd1,
                             nf_tk, ns_tk, ph_tk, str_tk);
        fin_use = is_term || is_semi || (eot && !fail);
        done    = is_term || fail || eot;

        // assemble up to two results
        res0   = '0;
        res1   = '0;
        push_n = 2'd0;
        if (!stopped_reg) begin
            if (!is_term && !is_semi && chr.valid) begin
                res0   = '{1'b0, 1'b0, chr.v2, chr.v1, chr.kind};
                push_n = 2'd1;
                if (fin_use && fin.valid) begin
                    res1   = '{1'b0, 1'b0, fin.v2, fin.v1, fin.kind};
                    push_n = 2'd2;
                end
            end else if (fin_use && fin.valid) begin
                res0   = '{1'b0, 1'b0, fin.v2, fin.v1, fin.kind};
                push_n = 2'd1;
            end
            if (done && push_n == 2'd0) begin
                res0.kind = KIND_NONE;
                push_n    = 2'd1;
            end
            if (push_n == 2'd2) begin
                res1.header_done  = done;
                res1.last_of_item = 1'b1;
            end else if (push_n == 2'd1) begin
                res0.header_done  = done;
                res0.last_of_item = 1'b1;
            end
        end
        if (!proc) push_n = 2'd0;

        // state update
        seg_len_next = seg_len_reg;
        cand_next    = cand_reg;
        nf_next      = nf_reg;
        ns_next      = ns_reg;
        phase_next   = phase_reg;
        str_len_next = str_len_reg;
        stopped_next = stopped_reg;
        if (proc) begin
            if (stopped_reg ? eot : (done || is_semi)) begin
                seg_len_next = '0;
                cand_next    = '1;
                nf_next      = '0;
                ns_next      = '0;
                phase_next   = PH_START;
                str_len_next = '0;
                stopped_next = stopped_reg ? 1'b0 : (done && !eot);
            end else if (!stopped_reg) begin
                seg_len_next = (seg_len_reg == 8'hFF) ? 8'hFF : seg_len_reg + 8'd1;
                cand_next    = cand_tk;
                nf_next      = nf_tk;
                ns_next      = ns_tk;
                phase_next   = ph_tk;
                str_len_next = str_tk;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_len_reg <= '0;
            cand_reg    <= '1;
            nf_reg      <= '0;
            ns_reg      <= '0;
            phase_reg   <= PH_START;
            str_len_reg <= '0;
            stopped_reg <= 1'b0;
        end else begin
            seg_len_reg <= seg_len_next;
            cand_reg    <= cand_next;
            nf_reg      <= nf_next;
            ns_reg      <= ns_next;
            phase_reg   <= phase_next;
            str_len_reg <= str_len_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result queue pointers and storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {1'b0, push_n} - {2'd0, pop};
        end
        if (push_n != 2'd0) fifo_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2) fifo_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    out_t head;
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {2'b00, head.last_of_item, head.v2, head.v1, head.kind};
    assign m_tlast  = head.header_done;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4) else $error("result queue over full");
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[53]) else $error("header end not last of byte");
    a_no_push_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc |-> push_n == 2'd0) else $error("result pushed without a byte");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid after reset");

endmodule
